// ----- sv/rbc_pkg.sv -----
`timescale 1ns / 1ps

package rbc_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int HEIGHT_LIMIT = 2048;
   localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

   localparam int COLOR_W    = 8;
   localparam int GEO_W      = 12;
   localparam int OFS_W      = 11;
   localparam int POS_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;
   localparam int RUN_LEN    = 3;
   localparam int LINE_W     = 2;

   localparam int WID_W = (GEO_W > COL_W + 1) ? GEO_W : COL_W + 1;
   localparam int HGT_W = (GEO_W > ROW_W + 1) ? GEO_W : ROW_W + 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REGION_BLUE   = 3'd0,
      CSR_REGION_GREEN  = 3'd1,
      CSR_REGION_RED    = 3'd2,
      CSR_IMAGE_WIDTH   = 3'd3,
      CSR_IMAGE_HEIGHT  = 3'd4,
      CSR_OFFSET_X      = 3'd5,
      CSR_OFFSET_Y      = 3'd6,
      CSR_EMIT_INTERIOR = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic             on_boundary;
   } result_type;

   // line word: bit 0 previous row, bit 1 row before it
   typedef struct packed {
      logic              rd_en;
      logic [COL_W-1:0]  rd_addr;
      logic              wr_en;
      logic [COL_W-1:0]  wr_addr;
      logic [LINE_W-1:0] wr_data;
   } line_access_type;

endpackage

// ----- sv/rbc_line_store.sv -----
`timescale 1ns / 1ps

module rbc_line_store (
   input  logic                            clock,
   input  logic                            reset,
   input  rbc_pkg::line_access_type        access,
   output logic [rbc_pkg::LINE_W-1:0]      rd_data
);

   logic [rbc_pkg::LINE_W-1:0] mem [rbc_pkg::MAX_WIDTH];
   logic [rbc_pkg::LINE_W-1:0] rd_ff;
   logic [rbc_pkg::LINE_W-1:0] fwd_data_ff;
   logic                       fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (access.wr_en) begin
         mem[access.wr_addr] <= access.wr_data;
      end
      if (access.rd_en) begin
         rd_ff       <= mem[access.rd_addr];
         fwd_data_ff <= access.wr_data;
      end
   end

   // forward a write that lands on the entry being read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (access.rd_en) begin
         fwd_hit_ff <= access.wr_en && (access.wr_addr == access.rd_addr);
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_ff;

endmodule

// ----- sv/rbc_result_run.sv -----
`timescale 1ns / 1ps

module rbc_result_run (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [rbc_pkg::RUN_LEN-1:0]       load_mask,
   input  rbc_pkg::result_type               load_res [rbc_pkg::RUN_LEN],
   output logic                              run_free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rbc_pkg::POS_W-1:0]         rsp_pos_x,
   output logic [rbc_pkg::POS_W-1:0]         rsp_pos_y,
   output logic                              rsp_on_boundary,
   output logic                              rsp_last_of_run
);

   logic [rbc_pkg::RUN_LEN-1:0] mask_ff;
   logic [rbc_pkg::RUN_LEN-1:0] mask_in;
   rbc_pkg::result_type         slot_ff [rbc_pkg::RUN_LEN];
   rbc_pkg::result_type         head;
   logic                        rsp_take;

   assign rsp_valid       = (mask_ff != '0);
   assign rsp_take        = rsp_valid && !rsp_stall;
   assign rsp_last_of_run = ((mask_ff & (mask_ff - 1'b1)) == '0);
   assign run_free        = !rsp_valid || (rsp_last_of_run && rsp_take);

   always_comb begin
      head = slot_ff[rbc_pkg::RUN_LEN-1];
      for (int i = rbc_pkg::RUN_LEN - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            head = slot_ff[i];
         end
      end
   end

   assign rsp_pos_x       = head.pos_x;
   assign rsp_pos_y       = head.pos_y;
   assign rsp_on_boundary = head.on_boundary;

   // drop the lowest pending word on each take
   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         mask_in = load_mask;
      end else if (rsp_take) begin
         mask_in = mask_ff & (mask_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= load_res;
      end
   end

endmodule

// ----- sv/region_boundary_classifier_core.sv -----
`timescale 1ns / 1ps

// Region boundary classifier. Pixels enter in raster order, one word per clock unless
// stalled; each boundary pixel of the region color (any such pixel with emit_interior
// set) is reported once with offset coordinates and a boundary/interior flag (image
// edge or any differing neighbor of the eight makes a boundary), in raster order but for
// the last row, interleaved with the row above. A pixel off the last row and column is
// decided one row and one column after it arrives. The result port delivers one word per
// cycle while rsp_stall is low, so a pixel with two or three results (row ends, last row)
// can stall the input while they drain. Match bits of the two previous rows live in a
// 2-bit-wide line memory of MAX_WIDTH entries, read and written back once per pixel;
// entries are always written before they affect a result, so no initialization pass runs.
// Writing image_width or image_height restarts the frame at column 0, row 0.

module region_boundary_classifier_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rbc_pkg::COLOR_W-1:0]        req_pixel_blue,
   input  logic [rbc_pkg::COLOR_W-1:0]        req_pixel_green,
   input  logic [rbc_pkg::COLOR_W-1:0]        req_pixel_red,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rbc_pkg::POS_W-1:0]          rsp_pos_x,
   output logic [rbc_pkg::POS_W-1:0]          rsp_pos_y,
   output logic                               rsp_on_boundary,
   output logic                               rsp_last_of_run,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = rbc_pkg::COL_W;
   localparam int ROW_W = rbc_pkg::ROW_W;
   localparam int WID_W = rbc_pkg::WID_W;
   localparam int HGT_W = rbc_pkg::HGT_W;
   localparam int POS_W = rbc_pkg::POS_W;

   logic [rbc_pkg::COLOR_W-1:0] blue_ff, green_ff, red_ff;
   logic [rbc_pkg::GEO_W-1:0]   width_ff, height_ff;
   logic [rbc_pkg::OFS_W-1:0]   offx_ff, offy_ff;
   logic                        interior_ff;
   logic                        csr_wr;
   logic                        geo_wr;

   logic [WID_W-1:0] width_ext, w_eff;
   logic [HGT_W-1:0] height_ext, h_eff;
   logic [COL_W-1:0] w_last;
   logic [ROW_W-1:0] h_last;

   logic [COL_W-1:0] col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   logic             accept;
   logic             cur_match;

   logic             s1_vld_ff, s1_vld_in;
   logic             s1_cur_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_col_ge1_ff, s1_row_ge1_ff, s1_col_is1_ff, s1_row_is1_ff;
   logic             s1_col_last_ff, s1_row_last_ff;
   logic             s1_adv;

   logic [8:0]                  win_ff, win_in;
   logic [rbc_pkg::LINE_W-1:0]  line_rd;
   logic                        prev1, prev2;
   rbc_pkg::line_access_type    line_acc;

   logic [rbc_pkg::RUN_LEN-1:0] res_mask;
   rbc_pkg::result_type         res [rbc_pkg::RUN_LEN];
   logic                        interior_b;
   logic [POS_W-1:0]            px_cur, py_cur;
   logic                        run_free;
   logic                        run_load;

   // configuration
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign geo_wr    = csr_wr && ((csr_index == rbc_pkg::CSR_IMAGE_WIDTH) ||
                                 (csr_index == rbc_pkg::CSR_IMAGE_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         blue_ff     <= '0;
         green_ff    <= '0;
         red_ff      <= '0;
         width_ff    <= rbc_pkg::GEO_W'(640);
         height_ff   <= rbc_pkg::GEO_W'(480);
         offx_ff     <= '0;
         offy_ff     <= '0;
         interior_ff <= 1'b0;
      end else if (csr_wr) begin
         case (csr_index)
            rbc_pkg::CSR_REGION_BLUE:   blue_ff     <= csr_data[rbc_pkg::COLOR_W-1:0];
            rbc_pkg::CSR_REGION_GREEN:  green_ff    <= csr_data[rbc_pkg::COLOR_W-1:0];
            rbc_pkg::CSR_REGION_RED:    red_ff      <= csr_data[rbc_pkg::COLOR_W-1:0];
            rbc_pkg::CSR_IMAGE_WIDTH:   width_ff    <= csr_data[rbc_pkg::GEO_W-1:0];
            rbc_pkg::CSR_IMAGE_HEIGHT:  height_ff   <= csr_data[rbc_pkg::GEO_W-1:0];
            rbc_pkg::CSR_OFFSET_X:      offx_ff     <= csr_data[rbc_pkg::OFS_W-1:0];
            rbc_pkg::CSR_OFFSET_Y:      offy_ff     <= csr_data[rbc_pkg::OFS_W-1:0];
            rbc_pkg::CSR_EMIT_INTERIOR: interior_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // effective geometry
   assign width_ext  = WID_W'(width_ff);
   assign height_ext = HGT_W'(height_ff);
   assign w_eff  = (width_ff == '0) ? WID_W'(1) :
                   (width_ext > WID_W'(rbc_pkg::MAX_WIDTH)) ? WID_W'(rbc_pkg::MAX_WIDTH) :
                   width_ext;
   assign h_eff  = (height_ff == '0) ? HGT_W'(1) :
                   (height_ext > HGT_W'(rbc_pkg::HEIGHT_LIMIT)) ?
                   HGT_W'(rbc_pkg::HEIGHT_LIMIT) : height_ext;
   assign w_last = COL_W'(w_eff - WID_W'(1));
   assign h_last = ROW_W'(h_eff - HGT_W'(1));

   // stage 0: position, match, line read
   assign req_stall = s1_vld_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign col_cur   = (WID_W'(col_ff) >= w_eff) ? '0 : col_ff;
   assign row_cur   = (HGT_W'(row_ff) >= h_eff) ? '0 : row_ff;
   assign cur_match = (req_pixel_blue == blue_ff) && (req_pixel_green == green_ff) &&
                      (req_pixel_red == red_ff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (geo_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_cur == w_last) begin
            col_in = '0;
            row_in = (row_cur == h_last) ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         s1_vld_ff <= 1'b0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         s1_vld_ff <= s1_vld_in;
      end
   end

   assign s1_vld_in = accept || (s1_vld_ff && !s1_adv);

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff      <= cur_match;
         s1_col_ff      <= col_cur;
         s1_row_ff      <= row_cur;
         s1_col_ge1_ff  <= (col_cur != '0);
         s1_row_ge1_ff  <= (row_cur != '0);
         s1_col_is1_ff  <= (col_cur == COL_W'(1));
         s1_row_is1_ff  <= (row_cur == ROW_W'(1));
         s1_col_last_ff <= (col_cur == w_last);
         s1_row_last_ff <= (row_cur == h_last);
      end
   end

   always_comb begin
      line_acc.rd_en   = accept;
      line_acc.rd_addr = col_cur;
      line_acc.wr_en   = s1_adv;
      line_acc.wr_addr = s1_col_ff;
      line_acc.wr_data = {prev1, s1_cur_ff};
   end

   rbc_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .access  (line_acc),
      .rd_data (line_rd)
   );

   // stage 1: window, decisions, write back
   assign prev1  = line_rd[0];
   assign prev2  = line_rd[1];
   assign win_in = {s1_cur_ff, prev1, prev2, win_ff[8:3]};

   assign px_cur = POS_W'(s1_col_ff) + POS_W'(offx_ff);
   assign py_cur = POS_W'(s1_row_ff) + POS_W'(offy_ff);
   assign interior_b = s1_col_is1_ff || s1_row_is1_ff || (win_in != 9'h1FF);

   always_comb begin
      res[0].pos_x       = px_cur - POS_W'(1);
      res[0].pos_y       = py_cur - POS_W'(1);
      res[0].on_boundary = interior_b;
      res[1].pos_x       = px_cur;
      res[1].pos_y       = py_cur - POS_W'(1);
      res[1].on_boundary = 1'b1;
      res[2].pos_x       = px_cur;
      res[2].pos_y       = py_cur;
      res[2].on_boundary = 1'b1;
      res_mask[0] = s1_row_ge1_ff && s1_col_ge1_ff && win_in[4] &&
                    (interior_b || interior_ff);
      res_mask[1] = s1_row_ge1_ff && s1_col_last_ff && prev1;
      res_mask[2] = s1_row_last_ff && s1_cur_ff;
   end

   assign s1_adv   = s1_vld_ff && (run_free || (res_mask == '0));
   assign run_load = s1_adv && (res_mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   rbc_result_run u_result_run (
      .clock           (clock),
      .reset           (reset),
      .load            (run_load),
      .load_mask       (res_mask),
      .load_res        (res),
      .run_free        (run_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_on_boundary (rsp_on_boundary),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// ----- sv/rbc_checker.sv -----
`timescale 1ns / 1ps

module rbc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [rbc_pkg::POS_W-1:0]  rsp_pos_x,
   input logic [rbc_pkg::POS_W-1:0]  rsp_pos_y,
   input logic                       rsp_on_boundary,
   input logic                       rsp_last_of_run
);

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_run |=> rsp_valid)
      else $error("run ended without a last word");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_hold_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_pos_x) && $stable(rsp_pos_y) &&
                                 $stable(rsp_on_boundary) && $stable(rsp_last_of_run))
      else $error("result word changed while stalled");

endmodule

bind region_boundary_classifier_core rbc_checker u_rbc_checker (.*);
